FILE: hdl/ipid_pkg.sv
// shared types and register codes for the incremental pid with integral separation
package ipid_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
	localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
	localparam logic [1:0] REG_DERIV_GAIN = 2'd2;
	localparam logic [1:0] REG_SEP_LIMIT  = 2'd3;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned VAL_W      = 32;
	localparam int unsigned GAIN_W     = 24;
	localparam int unsigned LIMIT_W    = 31;

	// reset gains are one over these, the limit is this many whole units
	localparam int unsigned PropDen    = 5;
	localparam int unsigned IntegDen   = 25;
	localparam int unsigned LimitUnits = 200;

	// gains and separation limit as seen by the datapath
	typedef struct packed {
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  integ_gain;
		logic [GAIN_W-1:0]  deriv_gain;
		logic [LIMIT_W-1:0] separation_limit;
	} ipid_cfg_t;

endpackage

FILE: hdl/ipid_cfg.sv
// configuration register file: gains and separation limit
module ipid_cfg import ipid_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output ipid_cfg_t             cfg
);

	localparam logic [63:0] ONE_64       = 64'd1 << FRAC_BITS;
	localparam logic [63:0] PROP_RST_64  = ONE_64 / PropDen;
	localparam logic [63:0] INTEG_RST_64 = ONE_64 / IntegDen;
	localparam logic [63:0] LIMIT_RST_64 = 64'(LimitUnits) << FRAC_BITS;

	ipid_cfg_t cfg_q;

	// register writes, data masked to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain        <= PROP_RST_64[GAIN_W-1:0];
			cfg_q.integ_gain       <= INTEG_RST_64[GAIN_W-1:0];
			cfg_q.deriv_gain       <= PROP_RST_64[GAIN_W-1:0];
			cfg_q.separation_limit <= LIMIT_RST_64[LIMIT_W-1:0];
		end else if (wr_en) begin
			case (wr_index)
				REG_PROP_GAIN:  cfg_q.prop_gain        <= wr_data[GAIN_W-1:0];
				REG_INTEG_GAIN: cfg_q.integ_gain       <= wr_data[GAIN_W-1:0];
				REG_DERIV_GAIN: cfg_q.deriv_gain       <= wr_data[GAIN_W-1:0];
				REG_SEP_LIMIT:  cfg_q.separation_limit <= wr_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/ipid_core.sv
// pid datapath: error, gain products, increment and controller state
module ipid_core import ipid_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ipid_cfg_t               cfg,
	input  logic                    step,
	input  logic signed [VAL_W-1:0] setpoint,
	output logic signed [VAL_W-1:0] drive_next,
	output logic                    integ_on
);

	localparam int unsigned SUM_W = 60;
	localparam int unsigned ACC_W = SUM_W + 1;

	// clamp a wide signed value to 32 bits
	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] vmax;
		logic signed [ACC_W-1:0] vmin;
		vmax = ACC_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}));
		vmin = ACC_W'(signed'({1'b1, {(VAL_W-1){1'b0}}}));
		if (v > vmax) begin
			sat_val = vmax[VAL_W-1:0];
		end else if (v < vmin) begin
			sat_val = vmin[VAL_W-1:0];
		end else begin
			sat_val = v[VAL_W-1:0];
		end
	endfunction

	logic signed [VAL_W-1:0] acc_q;
	logic signed [VAL_W-1:0] err1_q;
	logic signed [VAL_W-1:0] err2_q;

	logic signed [VAL_W:0]   err_wide;
	logic signed [VAL_W-1:0] err;
	logic        [VAL_W-1:0] err_mag;
	logic        [GAIN_W:0]  gain_pd;
	logic        [GAIN_W+1:0] gain_h;
	logic signed [57:0]      prod_pd;
	logic signed [56:0]      prod_i;
	logic signed [58:0]      prod_h1;
	logic signed [56:0]      prod_h2;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] inc;
	logic signed [ACC_W-1:0] acc_wide;

	// error against the accumulated output, saturated
	assign err_wide = (VAL_W+1)'(setpoint) - (VAL_W+1)'(acc_q);
	assign err      = sat_val(ACC_W'(err_wide));
	assign err_mag  = err[VAL_W-1] ? (~err + VAL_W'(1)) : err;
	assign integ_on = !(err_mag > {1'b0, cfg.separation_limit});

	// terms regrouped: (kp+kd)e + ki e - (kp+2kd)e1 + kd e2
	assign gain_pd = {1'b0, cfg.prop_gain} + {1'b0, cfg.deriv_gain};
	assign gain_h  = {2'b00, cfg.prop_gain} + {1'b0, cfg.deriv_gain, 1'b0};
	assign prod_pd = $signed({1'b0, gain_pd}) * err;
	assign prod_i  = $signed({1'b0, cfg.integ_gain}) * err;
	assign prod_h1 = $signed({1'b0, gain_h}) * err1_q;
	assign prod_h2 = $signed({1'b0, cfg.deriv_gain}) * err2_q;

	// sum at full precision, floor shift, saturating accumulate
	always_comb begin
		sum = SUM_W'(prod_pd) - SUM_W'(prod_h1) + SUM_W'(prod_h2);
		if (integ_on) begin
			sum = sum + SUM_W'(prod_i);
		end
		inc        = sum >>> FRAC_BITS;
		acc_wide   = ACC_W'(acc_q) + ACC_W'(inc);
		drive_next = sat_val(acc_wide);
	end

	// controller state advances once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			err1_q <= '0;
			err2_q <= '0;
		end else if (step) begin
			acc_q  <= drive_next;
			err1_q <= err;
			err2_q <= err1_q;
		end
	end

endmodule

FILE: hdl/incremental_pid_integral_separation.sv
// top level: incremental pid with integral separation, handshakes and registers
//
//   channel | direction | handshake          | payload
//   in      | to block  | in_valid/in_ready   | setpoint
//   out     | from block| out_valid/out_ready | drive_value, integral_active
//   cfg     | to block  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one word per cycle sustained while out_ready stays high; a word passes the input register,
// then the result register, before its result is presented; the rate is set by the
// combinational feedback through the error, one gain multiply and the saturating accumulate.
// reset clears the state and loads the default gains and limit; cfg_ready is always high.
// a stalled result holds in the result register while one more word waits in the input
// register; in_ready drops only when both are full.
module incremental_pid_integral_separation import ipid_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [VAL_W-1:0] setpoint,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] drive_value,
	output logic                    integral_active,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	ipid_cfg_t cfg;

	logic                    valid_s1;
	logic signed [VAL_W-1:0] setpoint_s1;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] drive_q;
	logic                    integ_q;
	logic                    advance;
	logic signed [VAL_W-1:0] drive_next;
	logic                    integ_on;

	assign cfg_ready = 1'b1;

	ipid_cfg #(
		.FRAC_BITS(FRAC_BITS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	// a word moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			setpoint_s1 <= setpoint;
		end
	end

	ipid_core #(
		.FRAC_BITS(FRAC_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (advance),
		.setpoint  (setpoint_s1),
		.drive_next(drive_next),
		.integ_on  (integ_on)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q <= drive_next;
			integ_q <= integ_on;
		end
	end

	assign out_valid       = out_valid_q;
	assign drive_value     = drive_q;
	assign integral_active = integ_q;

endmodule
